### hdl/assert_macros.svh
// Assertion macros used by the deque sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error("assertion failed");

`endif

### hdl/dq_pkg.sv
// Shared types and constants of the circular deque.
package dq_pkg;

	localparam int DATA_W = 32;

	// Command codes carried on the input tuser
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_DUMP       = 3'd4
	} cmd_t;

	// Result status codes carried on the output tuser
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	// One result transaction
	typedef struct packed {
		status_t                    status;
		logic signed [DATA_W-1:0]   data_out;
		logic                       last;
	} result_t;

endpackage

### hdl/dq_ram.sv
// Element store of the deque: one write port, one registered read port.
module dq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic signed [dq_pkg::DATA_W-1:0]   wdata,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic signed [dq_pkg::DATA_W-1:0]   rdata
);
	import dq_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/dq_ctrl.sv
// Deque sequencer: pointers, occupancy and the pop/dump read walk.
`include "assert_macros.svh"

module dq_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int OW    = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  dq_pkg::cmd_t                       in_cmd,
	input  logic signed [dq_pkg::DATA_W-1:0]   in_value,
	input  logic                               out_free,
	output logic                               res_valid,
	output dq_pkg::result_t                    res,
	output logic                               we,
	output logic [AW-1:0]                      waddr,
	output logic signed [dq_pkg::DATA_W-1:0]   wdata,
	output logic                               re,
	output logic [AW-1:0]                      raddr,
	input  logic signed [dq_pkg::DATA_W-1:0]   rdata
);
	import dq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [OW-1:0] left_q, left_d;
	logic          accept;
	logic          full;
	logic          empty;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign full     = (occ_q == OW'(DEPTH));
	assign empty    = (occ_q == '0);
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign wdata    = in_value;

	// Decode the command, update pointers, start memory reads and emit results
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		occ_d     = occ_q;
		ptr_d     = ptr_q;
		left_d    = left_q;
		we        = 1'b0;
		waddr     = tail_q;
		re        = 1'b0;
		raddr     = head_q;
		res_valid = 1'b0;
		res       = '{status: STAT_OK, data_out: '0, last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd) inside
						CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
							res_valid = 1'b1;
							if (full) begin
								res.status = STAT_OVERFLOW;
							end else begin
								we    = 1'b1;
								occ_d = occ_q + 1'b1;
								if (in_cmd == CMD_PUSH_FRONT) begin
									waddr  = idx_dec(head_q);
									head_d = idx_dec(head_q);
								end else begin
									waddr  = tail_q;
									tail_d = idx_inc(tail_q);
								end
							end
						end
						CMD_POP_FRONT, CMD_POP_REAR: begin
							if (empty) begin
								res_valid  = 1'b1;
								res.status = STAT_UNDERFLOW;
							end else begin
								re      = 1'b1;
								occ_d   = occ_q - 1'b1;
								left_d  = OW'(1);
								state_d = ST_READ;
								if (in_cmd == CMD_POP_FRONT) begin
									raddr  = head_q;
									head_d = idx_inc(head_q);
								end else begin
									raddr  = idx_dec(tail_q);
									tail_d = idx_dec(tail_q);
								end
							end
						end
						CMD_DUMP: begin
							if (empty) begin
								res_valid  = 1'b1;
								res.status = STAT_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								ptr_d   = idx_inc(head_q);
								left_d  = occ_q;
								state_d = ST_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				// Emit the read word, then fetch the next one of a dump
				if (out_free) begin
					res_valid    = 1'b1;
					res.data_out = rdata;
					res.last     = (left_q == OW'(1));
					if (left_q == OW'(1)) begin
						state_d = ST_IDLE;
					end else begin
						re     = 1'b1;
						raddr  = ptr_q;
						ptr_d  = idx_inc(ptr_q);
						left_d = left_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			ptr_q   <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			ptr_q   <= ptr_d;
			left_q  <= left_d;
		end
	end

	// Tail must sit occupancy slots after head, modulo the depth
	logic [AW:0] chk_sum;
	logic [AW:0] chk_tail;
	assign chk_sum  = {1'b0, head_q} + (AW+1)'(occ_q);
	assign chk_tail = (chk_sum >= (AW+1)'(DEPTH)) ? chk_sum - (AW+1)'(DEPTH) : chk_sum;

	`ASSERT_ALWAYS(a_occ_range, clk, arst_n, occ_q <= OW'(DEPTH))
	`ASSERT_ALWAYS(a_ptr_consistent, clk, arst_n, chk_tail == {1'b0, tail_q})
	`ASSERT_IMPLIES(a_res_room, clk, arst_n, res_valid, out_free)
	`ASSERT_IMPLIES(a_walk_left, clk, arst_n, state_q == ST_READ, left_q != '0)

endmodule

### hdl/circular_deque_core.sv
// Top level of the circular deque: stream ports, result register and instances.
//
// A double-ended queue of DEPTH signed 32-bit words in a circular single-port-
// write, registered-read memory. Commands arrive on the slave side (s_tuser
// selects push front, push rear, pop front, pop rear or dump); results leave on
// the master side with a status in m_tuser and m_tlast on the final result of a
// command. One command is in work at a time. A push, an overflow, an underflow
// or a dump of an empty queue is answered from the idle state, with no memory
// read. A pop is answered from the read state, since the word comes out of the
// memory in the cycle after its read. A dump makes one memory read per element,
// issued back to back while the output side takes results; input stays held off
// until the last element has been handed to the result register. Backpressure
// on the master side holds off each of these steps. The memory needs no
// initialization after reset.
module circular_deque_core #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] push_value
	input  logic [2:0]  s_tuser,   // [2:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data_out
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);
	import dq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);

	logic                     out_free;
	logic                     res_valid;
	result_t                  res;
	result_t                  out_q;
	logic                     out_valid_q;
	logic                     we;
	logic [AW-1:0]            waddr;
	logic signed [DATA_W-1:0] wdata;
	logic                     re;
	logic [AW-1:0]            raddr;
	logic signed [DATA_W-1:0] rdata;

	assign out_free = !out_valid_q || m_tready;

	dq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.OW    (OW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser)),
		.in_value  (s_tdata),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	dq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Hold the result transaction until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.data_out;
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

endmodule

### bench/tb_circular_deque_core.sv
// Self-checking bench for circular_deque_core: directed table, then random traffic.
module tb_circular_deque_core;
	import dq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_ITEMS = 60;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DIR_ROWS = 15;

	// Command codes the block must ignore
	localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

	// One row of the directed table; typed rows carry their single expected result
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] value;
		int          reps;
		bit          typed;
		status_t     status;
		logic [31:0] data;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;    // [31:0] push_value
	logic [2:0]  s_tuser = '0;    // [2:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] data_out
	logic [1:0]  m_tuser;         // [1:0] status
	logic        m_tlast;

	// Shadow copy of the deque
	logic [31:0] mdl_slots [DEPTH];
	logic [3:0]  mdl_head = '0;
	logic [3:0]  mdl_tail = '0;
	logic [4:0]  mdl_count = '0;

	result_t     step_results [$];
	result_t     pending_results [$];
	result_t     want;

	int          error_count = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          quiet_tail = 1'b0;

	dir_row_t dir_table [DIR_ROWS] = '{
		'{CMD_POP_FRONT,  32'h0000_0000, 1, 1'b1, STAT_UNDERFLOW, 32'h0},
		'{CMD_POP_REAR,   32'h1234_5678, 1, 1'b1, STAT_UNDERFLOW, 32'h0},
		'{CMD_DUMP,       32'hDEAD_BEEF, 1, 1'b1, STAT_EMPTY,     32'h0},
		'{CMD_PUSH_REAR,  32'h7FFF_FFFF, 1, 1'b1, STAT_OK,        32'h0},
		'{CMD_PUSH_FRONT, 32'h8000_0000, 1, 1'b1, STAT_OK,        32'h0},
		'{CMD_PUSH_REAR,  32'h0000_0000, 1, 1'b1, STAT_OK,        32'h0},
		'{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b1, STAT_OK,        32'h0},
		'{CMD_DUMP,       32'h0000_0000, 1, 1'b0, STAT_OK,        32'h0},
		'{CMD_POP_FRONT,  32'h0000_0000, 1, 1'b0, STAT_OK,        32'h0},
		'{CMD_POP_REAR,   32'h0000_0000, 1, 1'b0, STAT_OK,        32'h0},
		'{CMD_PUSH_REAR,  32'hA5A5_A5A5, 7, 1'b1, STAT_OK,        32'h0},
		'{CMD_PUSH_FRONT, 32'h5A5A_5A5A, 7, 1'b1, STAT_OK,        32'h0},
		'{CMD_PUSH_FRONT, 32'h0000_0001, 1, 1'b1, STAT_OVERFLOW,  32'h0},
		'{CMD_PUSH_REAR,  32'hFFFF_FFFE, 1, 1'b1, STAT_OVERFLOW,  32'h0},
		'{CMD_DUMP,       32'h0000_0000, 1, 1'b0, STAT_OK,        32'h0}
	};

	circular_deque_core #(
		.DEPTH(DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stall the result side in random bursts; keep it open in the quiet tail
	always @(posedge clk) begin
		if (quiet_tail) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest pending expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d data %h last %0d",
					m_tuser, m_tdata, m_tlast);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
					error_count++;
				end
				if (m_tdata !== want.data_out) begin
					$error("data_out mismatch: expected %h, actual %h", want.data_out, m_tdata);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// Apply one command to the shadow deque and list the results it causes
	task automatic deque_model_apply(input logic [2:0] cmd, input logic [31:0] value);
		logic [3:0] idx;
		int k;
		step_results.delete();
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (mdl_count >= DEPTH) begin
					step_results.push_back(result_t'{STAT_OVERFLOW, 32'sd0, 1'b1});
				end else begin
					if (cmd == CMD_PUSH_FRONT) begin
						mdl_head = mdl_head - 4'd1;
						mdl_slots[mdl_head] = value;
					end else begin
						mdl_slots[mdl_tail] = value;
						mdl_tail = mdl_tail + 4'd1;
					end
					mdl_count = mdl_count + 5'd1;
					step_results.push_back(result_t'{STAT_OK, 32'sd0, 1'b1});
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (mdl_count == 0) begin
					step_results.push_back(result_t'{STAT_UNDERFLOW, 32'sd0, 1'b1});
				end else begin
					if (cmd == CMD_POP_FRONT) begin
						idx = mdl_head;
						mdl_head = mdl_head + 4'd1;
					end else begin
						mdl_tail = mdl_tail - 4'd1;
						idx = mdl_tail;
					end
					mdl_count = mdl_count - 5'd1;
					step_results.push_back(result_t'{STAT_OK, mdl_slots[idx], 1'b1});
				end
			end
			CMD_DUMP: begin
				if (mdl_count == 0) begin
					step_results.push_back(result_t'{STAT_EMPTY, 32'sd0, 1'b1});
				end else begin
					idx = mdl_head;
					for (k = 0; k < mdl_count; k++) begin
						step_results.push_back(result_t'{STAT_OK, mdl_slots[idx],
							(k + 1 == mdl_count)});
						idx = idx + 4'd1;
					end
				end
			end
			default: begin
				// reserved codes: no result, no state change
			end
		endcase
	endtask

	// Offer one command, after an optional idle burst, and hold it until taken
	task automatic send_command(input logic [2:0] cmd, input logic [31:0] value);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Favor the extremes of the word range
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Pick a command: fill epochs lean on pushes, drain epochs on pops
	function automatic logic [2:0] pick_command(input bit fill_mode);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll >= 97) return 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		if (roll >= 90) return CMD_DUMP;
		if (fill_mode) begin
			if (roll < 40) return CMD_PUSH_FRONT;
			if (roll < 80) return CMD_PUSH_REAR;
			if (roll < 85) return CMD_POP_FRONT;
			return CMD_POP_REAR;
		end
		if (roll < 10) return CMD_PUSH_FRONT;
		if (roll < 20) return CMD_PUSH_REAR;
		if (roll < 55) return CMD_POP_FRONT;
		return CMD_POP_REAR;
	endfunction

	initial begin
		int r;
		int n;
		int counted;
		int epoch_left;
		bit fill_mode;
		logic [2:0] cmd;

		counted = 0;
		epoch_left = 0;
		fill_mode = 1'b1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		for (r = 0; r < DIR_ROWS; r++) begin
			for (n = 0; n < dir_table[r].reps; n++) begin
				send_command(dir_table[r].cmd, dir_table[r].value);
				deque_model_apply(dir_table[r].cmd, dir_table[r].value);
				if (dir_table[r].typed)
					pending_results.push_back(result_t'{dir_table[r].status,
						dir_table[r].data, 1'b1});
				else
					foreach (step_results[i]) pending_results.push_back(step_results[i]);
			end
		end

		// Random traffic in fill and drain epochs
		while (counted < RANDOM_ITEMS) begin
			if (epoch_left == 0) begin
				fill_mode = 1'($urandom_range(0, 1));
				epoch_left = $urandom_range(20, 60);
			end
			epoch_left--;
			if (counted >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet_tail = 1'b1;
			cmd = pick_command(fill_mode);
			send_command(cmd, pick_value());
			deque_model_apply(cmd, s_tdata);
			foreach (step_results[i]) pending_results.push_back(step_results[i]);
			if (cmd <= CMD_DUMP)
				counted++;
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then let the block settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### circular_deque_core.f
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ctrl.sv
hdl/circular_deque_core.sv
bench/tb_circular_deque_core.sv
